// ----- src/rwws_pkg.sv -----
// Shared types, constants and helper functions of the repeated word window scanner.
// No dependencies; every other file of the block imports this package.
package rwws_pkg;

    localparam int WINDOW_MAX_DEF    = 64;
    localparam int POSITION_BITS_DEF = 40;

    localparam int WORD_BITS      = 64;
    localparam int OFFSET_BITS    = 40;
    localparam int COUNT_BITS     = 7;
    localparam int SIZE_BITS      = 2;
    localparam int WINDOW_BITS    = 7;
    localparam int CFG_INDEX_BITS = 3;
    localparam int GROUP_SIZE     = 8;
    localparam int GROUP_BITS     = 4;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WORD_SIZE  = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW     = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MATCHES    = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RANGE_EN   = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RANGE_LOW  = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RANGE_HIGH = 3'd5;

    // word size codes; any other code means eight bytes
    localparam logic [SIZE_BITS-1:0] SIZE_2B = 2'd0;
    localparam logic [SIZE_BITS-1:0] SIZE_4B = 2'd1;
    localparam logic [SIZE_BITS-1:0] SIZE_8B = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CAND,
        ST_CMP,
        ST_START,
        ST_WAIT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic shift;
        logic cmp;
        logic follow;
    } t_cell_ctl;

    typedef struct packed {
        logic start;
        logic extra;
    } t_cnt_ctl;

    function automatic logic [WORD_BITS-1:0] size_mask(input logic [SIZE_BITS-1:0] code);
        logic [WORD_BITS-1:0] m;
        case (code)
            SIZE_2B: m = 64'h0000_0000_0000_FFFF;
            SIZE_4B: m = 64'h0000_0000_FFFF_FFFF;
            SIZE_8B: m = '1;
            default: m = '1;
        endcase
        return m;
    endfunction

    // log2 of the word size in bytes
    function automatic logic [1:0] size_shift(input logic [SIZE_BITS-1:0] code);
        logic [1:0] s;
        case (code)
            SIZE_2B: s = 2'd1;
            SIZE_4B: s = 2'd2;
            SIZE_8B: s = 2'd3;
            default: s = 2'd3;
        endcase
        return s;
    endfunction

endpackage

// ----- src/rwws_cell.sv -----
// One cell of the window shift line: holds one stored word and compares it
// against the broadcast candidate. Depends on rwws_pkg.
module rwws_cell import rwws_pkg::*; (
    input  logic                 i_clk,
    input  t_cell_ctl            i_ctl,
    input  logic [WORD_BITS-1:0] i_word,
    input  logic [WORD_BITS-1:0] i_cand,
    output logic [WORD_BITS-1:0] o_word,
    output logic                 o_eq
);

    logic [WORD_BITS-1:0] r_word;
    logic                 r_eq;

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_word <= i_word;
        end
        if (i_ctl.cmp) begin
            r_eq <= i_ctl.follow && (r_word == i_cand);
        end
    end

    assign o_word = r_word;
    assign o_eq   = r_eq;

endmodule

// ----- src/rwws_count.sv -----
// Equal-bit counter: sums the cells' match bits in groups of eight, then
// accumulates eight groups per cycle. Depends on rwws_pkg.
module rwws_count import rwws_pkg::*; #(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  t_cnt_ctl                             i_ctl,
    input  logic [WINDOW_MAX-1:0]                i_eq,
    output logic                                 o_done,
    output logic [$clog2(WINDOW_MAX+1)-1:0]      o_total
);

    localparam int CW = $clog2(WINDOW_MAX + 1);
    localparam int NG = (WINDOW_MAX + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int NA = (NG + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int AW = (NA > 1) ? $clog2(NA) : 1;

    logic [GROUP_BITS-1:0] r_grp [NG];
    logic [GROUP_BITS-1:0] n_grp [NG];
    logic [CW-1:0]         r_acc;
    logic [CW-1:0]         step_sum;
    logic [AW-1:0]         r_left;
    logic                  r_busy;
    logic                  r_done;

    // group popcounts of the incoming match bits
    always_comb begin
        for (int g = 0; g < NG; g++) begin
            n_grp[g] = '0;
            for (int b = 0; b < GROUP_SIZE; b++) begin
                if (g * GROUP_SIZE + b < WINDOW_MAX) begin
                    n_grp[g] = n_grp[g] + GROUP_BITS'(i_eq[g * GROUP_SIZE + b]);
                end
            end
        end
    end

    // sum of the lowest eight groups
    always_comb begin
        step_sum = '0;
        for (int j = 0; j < GROUP_SIZE; j++) begin
            if (j < NG) begin
                step_sum = step_sum + CW'(r_grp[j]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            for (int g = 0; g < NG; g++) begin
                r_grp[g] <= n_grp[g];
            end
            r_acc  <= CW'(i_ctl.extra);
            r_left <= AW'(NA - 1);
        end else if (r_busy) begin
            // advance the groups down by eight
            for (int g = 0; g < NG; g++) begin
                r_grp[g] <= (g + GROUP_SIZE < NG) ? r_grp[(g + GROUP_SIZE) % NG] : '0;
            end
            r_acc  <= r_acc + step_sum;
            r_left <= r_left - AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_left == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_done  = r_done;
    assign o_total = r_acc;

endmodule

// ----- src/repeated_word_window_scanner_top.sv -----
// Top level of the repeated word window scanner: configuration registers,
// sequencer, shift line of rwws_cell and the rwws_count popcount unit.
// Depends on rwws_pkg, rwws_cell and rwws_count.
//
// Usage:
//   Image words enter on the request channel (i_valid / o_ready) together with
//   i_restart, which marks word 0 of a new image. Each word becomes the newest
//   entry of a shift line of WINDOW_MAX cells; the word window_words places
//   back is the candidate and is judged against the words after it.
//   A report leaves on the result channel (o_valid / i_ready) with the
//   candidate's byte offset and its equal count; most words produce none.
//   Words are taken one at a time: a new word is accepted only in the idle
//   state, to which the sequencer returns after walking candidate select, cell
//   compare, group popcount and the accumulation of eight groups per cycle.
//   A report enters the output register when the final step completes.
//   A report waiting in the output register does not block acceptance: the
//   next word is compared and counted, and holds in its final step until the
//   output register is free. Shifting the line happens only in that step.
//   Reset restores the register defaults and clears position, next eligible
//   candidate, fill count and the output valid; the stored words need none.
//   Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data
//   while the block is idle; unknown indexes are ignored.
module repeated_word_window_scanner_top import rwws_pkg::*; #(
    parameter int WINDOW_MAX    = WINDOW_MAX_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration
    input  logic                      i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [WORD_BITS-1:0]      i_cfg_data,
    // request channel
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [WORD_BITS-1:0]      i_word_value,
    input  logic                      i_restart,
    // result channel
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [OFFSET_BITS-1:0]    o_byte_offset,
    output logic [COUNT_BITS-1:0]     o_equal_count
);

    localparam int FW = $clog2(WINDOW_MAX + 1);
    localparam int OW = (POSITION_BITS + 3 > OFFSET_BITS) ? POSITION_BITS + 3 : OFFSET_BITS;

    // configuration registers
    logic [SIZE_BITS-1:0]   r_size_code;
    logic [WINDOW_BITS-1:0] r_window;
    logic [COUNT_BITS-1:0]  r_matches;
    logic                   r_range_en;
    logic [WORD_BITS-1:0]   r_range_lo;
    logic [WORD_BITS-1:0]   r_range_hi;

    // control state
    t_state                 r_state;
    t_state                 n_state;
    logic [POSITION_BITS-1:0] r_pos;
    logic [POSITION_BITS-1:0] r_next;
    logic [FW-1:0]          r_fill;
    logic                   r_out_valid;

    // per-request working registers
    logic [WORD_BITS-1:0]   r_v;
    logic [WORD_BITS-1:0]   r_cand;
    logic [FW-1:0]          r_w;
    logic [POSITION_BITS-1:0] r_p;
    logic                   r_judge;
    logic                   r_elig;
    logic                   r_v_eq;
    logic                   r_first_eq;
    logic [OFFSET_BITS-1:0] r_offset;
    logic [COUNT_BITS-1:0]  r_count;

    // combinational
    logic                   accept;
    logic                   out_free;
    logic                   advance;
    logic                   report;
    logic [FW-1:0]          w_clamp;
    logic [WORD_BITS-1:0]   cand_sel;
    logic                   first_sel;
    logic [WORD_BITS-1:0]   rep;
    logic                   all_same;
    logic                   in_range;
    logic [OW-1:0]          offset_wide;
    t_cnt_ctl               cnt_ctl;
    logic                   cnt_done;
    logic [FW-1:0]          cnt_total;
    logic                   shift_en;
    logic                   cmp_en;

    logic [WORD_BITS-1:0]   cell_word [WINDOW_MAX];
    logic [WINDOW_MAX-1:0]  cell_eq;

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        n_state       = r_state;
        o_ready       = 1'b0;
        cmp_en        = 1'b0;
        cnt_ctl.start = 1'b0;
        cnt_ctl.extra = r_v_eq;
        advance       = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_state = ST_CAND;
                end
            end
            ST_CAND: begin
                n_state = ST_CMP;
            end
            ST_CMP: begin
                cmp_en  = 1'b1;
                n_state = ST_START;
            end
            ST_START: begin
                cnt_ctl.start = 1'b1;
                n_state       = ST_WAIT;
            end
            ST_WAIT: begin
                if (cnt_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold here until the output register can take a report
                if (out_free) begin
                    advance = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign accept   = i_valid && o_ready;
    assign shift_en = advance;

    // ---------------------------------------------------------------
    // datapath helpers
    // ---------------------------------------------------------------
    always_comb begin
        if (r_window == '0) begin
            w_clamp = FW'(1);
        end else if (32'(r_window) > 32'(WINDOW_MAX)) begin
            w_clamp = FW'(WINDOW_MAX);
        end else begin
            w_clamp = FW'(r_window);
        end
    end

    // candidate sits in cell W-1, first follower in cell W-2
    always_comb begin
        cand_sel  = '0;
        first_sel = 1'b0;
        for (int i = 0; i < WINDOW_MAX; i++) begin
            if (32'(i) + 32'd1 == 32'(r_w)) begin
                cand_sel = cand_sel | cell_word[i];
            end
            if (32'(i) + 32'd2 == 32'(r_w)) begin
                first_sel = first_sel | cell_eq[i];
            end
        end
    end

    // a word whose bytes are all equal is never a candidate
    assign rep      = {8{r_cand[7:0]}} & size_mask(r_size_code);
    assign all_same = (r_cand == rep);
    assign in_range = !r_range_en || ((r_cand >= r_range_lo) && (r_cand <= r_range_hi));

    assign report      = r_elig && (32'(cnt_total) >= 32'(r_matches));
    assign offset_wide = OW'(r_p) << size_shift(r_size_code);

    // ---------------------------------------------------------------
    // control registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_code <= SIZE_8B;
            r_window    <= WINDOW_BITS'(8);
            r_matches   <= COUNT_BITS'(2);
            r_range_en  <= 1'b0;
            r_range_lo  <= '0;
            r_range_hi  <= '1;
            r_pos       <= '0;
            r_next      <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_WORD_SIZE:  r_size_code <= i_cfg_data[SIZE_BITS-1:0];
                    CFG_WINDOW:     r_window    <= i_cfg_data[WINDOW_BITS-1:0];
                    CFG_MATCHES:    r_matches   <= i_cfg_data[COUNT_BITS-1:0];
                    CFG_RANGE_EN:   r_range_en  <= i_cfg_data[0];
                    CFG_RANGE_LOW:  r_range_lo  <= i_cfg_data;
                    CFG_RANGE_HIGH: r_range_hi  <= i_cfg_data;
                    default: ;
                endcase
            end
            // restart clears position and window before the word is judged
            if (accept && i_restart) begin
                r_pos  <= '0;
                r_next <= '0;
                r_fill <= '0;
            end
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (advance) begin
                if (report) begin
                    r_out_valid <= 1'b1;
                    r_next      <= r_p + POSITION_BITS'(r_w);
                end
                r_pos <= r_pos + POSITION_BITS'(1);
                if (32'(r_fill) < 32'(WINDOW_MAX)) begin
                    r_fill <= r_fill + FW'(1);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // payload registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_v <= i_word_value & size_mask(r_size_code);
            r_w <= w_clamp;
        end
        if (r_state == ST_CAND) begin
            r_cand  <= cand_sel;
            r_p     <= r_pos - POSITION_BITS'(r_w);
            r_judge <= (32'(r_fill) >= 32'(r_w));
        end
        if (r_state == ST_CMP) begin
            r_v_eq <= (r_v == r_cand);
            r_elig <= r_judge && (r_p >= r_next) && !all_same && in_range;
        end
        if (r_state == ST_START) begin
            r_first_eq <= (32'(r_w) >= 32'd2) ? first_sel : r_v_eq;
        end
        if (advance && report) begin
            r_offset <= offset_wide[OFFSET_BITS-1:0];
            // with no matches needed the report fires at the first follower
            r_count  <= (r_matches == '0) ? COUNT_BITS'(r_first_eq) : r_matches;
        end
    end

    // ---------------------------------------------------------------
    // shift line of cells; cell 0 holds the newest stored word
    // ---------------------------------------------------------------
    for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
        t_cell_ctl            ctl;
        logic [WORD_BITS-1:0] word_in;

        assign ctl.shift  = shift_en;
        assign ctl.cmp    = cmp_en;
        assign ctl.follow = (32'(i) + 32'd2 <= 32'(r_w));

        if (i == 0) begin : g_head
            assign word_in = r_v;
        end else begin : g_body
            assign word_in = cell_word[i-1];
        end

        rwws_cell u_cell (
            .i_clk  (i_clk),
            .i_ctl  (ctl),
            .i_word (word_in),
            .i_cand (r_cand),
            .o_word (cell_word[i]),
            .o_eq   (cell_eq[i])
        );
    end

    rwws_count #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_count (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (cnt_ctl),
        .i_eq    (cell_eq),
        .o_done  (cnt_done),
        .o_total (cnt_total)
    );

    assign o_valid       = r_out_valid;
    assign o_byte_offset = r_offset;
    assign o_equal_count = r_count;

endmodule
